// File: rtl/lrs_pkg.sv
// Package for the link reconnect supervisor.
// Holds the state, action and register-index codes plus fixed constants.
// No dependencies.
package lrs_pkg;

  typedef enum logic [2:0] {
    SUP_OFF         = 3'd0,
    SUP_WAIT_LINK   = 3'd1,
    SUP_IDLE        = 3'd2,
    SUP_OPENING     = 3'd3,
    SUP_AWAIT_REPLY = 3'd4,
    SUP_LIVE        = 3'd5,
    SUP_FAULT       = 3'd6
  } state_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_OPEN        = 3'd1,
    ACT_SEND_SOURCE = 3'd2,
    ACT_SEND_ROVER  = 3'd3,
    ACT_CLOSE       = 3'd4,
    ACT_TRANSFER    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    CFG_ROLE_MODE     = 3'd0,
    CFG_RETRY_INITIAL = 3'd1,
    CFG_RETRY_MAX     = 3'd2,
    CFG_HS_TIMEOUT    = 3'd3,
    CFG_ERROR_PAUSE   = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] ROLE_SOURCE = 2'd1;
  localparam logic [1:0] ROLE_ROVER  = 2'd2;

  // Largest byte count credited for one transfer pass
  localparam logic [12:0] CHUNK_BYTES = 13'd256;

  localparam logic [15:0] RETRY_INITIAL_RST = 16'd1000;
  localparam logic [15:0] RETRY_MAX_RST     = 16'd30000;
  localparam logic [15:0] HS_TIMEOUT_RST    = 16'd5000;
  localparam logic [19:0] ERROR_PAUSE_RST   = 20'd60000;

  localparam int unsigned IN_BYTES  = 7;
  localparam int unsigned OUT_BYTES = 7;

  // Input item fields after unpacking from tdata
  typedef struct packed {
    logic [8:0]  bytes_moved;
    logic        session_alive;
    logic        reply_fatal;
    logic        reply_accepted;
    logic        reply_seen;
    logic        request_ok;
    logic        open_ok;
    logic        server_known;
    logic        link_up;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item fields, packed in tdata order (lowest field last here)
  typedef struct packed {
    logic [15:0] retry_delay_out;
    logic [31:0] byte_total_out;
    logic        streaming_flag;
    action_e     action;
    state_e      state_code;
  } out_item_t;

endpackage

// File: rtl/link_reconnect_supervisor.sv
// Link reconnect supervisor: top level, a single registered pass per item.
// Depends on lrs_pkg for state, action and register codes.
//
// The supervisor walks a caster connection through disabled, wait link,
// disconnected, connecting, handshake, streaming and error, driven by one
// input item per pass that carries the current millisecond time, link and
// outcome flags and a byte count. Each accepted item yields exactly one
// result item: the state after the pass, the action taken in it, a
// streaming flag, the wrapping byte total and the current reconnect delay.
// An item is held in the input register; the next-state logic (three
// 32-bit subtract-and-compare paths) writes the state registers and the
// result register at the same edge, so the block sustains one item per
// clock while results are taken. The block holds up to two items: while a
// result waits on the output, an empty input register still takes one
// more item, and only then is the input held off. The reconnect delay
// doubles up to retry_max_ms on each failure but a fatal reply or dropped
// session, and returns to retry_initial_ms on an accepted reply or after
// the error pause. Timeouts compare the wrapping difference between now_ms
// and a stored start time. Writing role_mode restarts the supervisor (wait
// link for source or rover, else disabled) and restores the delay; write
// registers only while the block is idle.
module link_reconnect_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [19:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: now_ms[31:0], link_up, server_known, open_ok, request_ok,
  // reply_seen, reply_accepted, reply_fatal, session_alive, bytes_moved[8:0], pad
  input  logic [8*lrs_pkg::IN_BYTES-1:0]  s_axis_tdata,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: state_code[2:0], action[2:0], streaming_flag,
  // byte_total_out[31:0], retry_delay_out[15:0], pad
  output logic [8*lrs_pkg::OUT_BYTES-1:0] m_axis_tdata
);

  // configuration registers
  logic [1:0]  role_q;
  logic [15:0] retry_init_q;
  logic [15:0] retry_max_q;
  logic [15:0] hs_timeout_q;
  logic [19:0] err_pause_q;

  // supervisor state
  lrs_pkg::state_e st_q, st_d;
  logic [15:0] delay_q, delay_d;
  logic [31:0] last_q, last_d;
  logic [31:0] hs_start_q, hs_start_d;
  logic [31:0] err_start_q, err_start_d;
  logic [31:0] total_q, total_d;
  lrs_pkg::action_e act;

  // pipeline registers
  logic               in_vld_q;
  lrs_pkg::in_item_t  in_q;
  logic               out_vld_q;
  lrs_pkg::out_item_t out_q;
  lrs_pkg::out_item_t out_d;

  logic out_ld;
  logic adv;
  logic role_wr;

  logic [31:0] since_last;
  logic [31:0] since_hs;
  logic [31:0] since_err;
  logic [16:0] delay_x2;
  logic [15:0] backoff_delay;
  logic [12:0] bytes_clip;

  // Output register loads when empty or being drained; the input register
  // hands over its item whenever the output can load.
  assign out_ld        = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_ld;
  assign s_axis_tready = !in_vld_q || out_ld;
  assign role_wr       = cfg_we_i && (cfg_addr_i == lrs_pkg::CFG_ROLE_MODE);

  // ---------------------------------------------------------------------------
  // Configuration registers; an index beyond the list is dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q       <= 2'd0;
      retry_init_q <= lrs_pkg::RETRY_INITIAL_RST;
      retry_max_q  <= lrs_pkg::RETRY_MAX_RST;
      hs_timeout_q <= lrs_pkg::HS_TIMEOUT_RST;
      err_pause_q  <= lrs_pkg::ERROR_PAUSE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lrs_pkg::CFG_ROLE_MODE:     role_q       <= cfg_wdata_i[1:0];
        lrs_pkg::CFG_RETRY_INITIAL: retry_init_q <= cfg_wdata_i[15:0];
        lrs_pkg::CFG_RETRY_MAX:     retry_max_q  <= cfg_wdata_i[15:0];
        lrs_pkg::CFG_HS_TIMEOUT:    hs_timeout_q <= cfg_wdata_i[15:0];
        lrs_pkg::CFG_ERROR_PAUSE:   err_pause_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[$bits(lrs_pkg::in_item_t)-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic: elapsed times, doubled delay, clipped byte count
  // ---------------------------------------------------------------------------
  assign since_last    = in_q.now_ms - last_q;
  assign since_hs      = in_q.now_ms - hs_start_q;
  assign since_err     = in_q.now_ms - err_start_q;
  assign delay_x2      = {delay_q, 1'b0};
  assign backoff_delay = (delay_x2 < {1'b0, retry_max_q}) ? delay_x2[15:0] : retry_max_q;
  assign bytes_clip    = ({4'd0, in_q.bytes_moved} > lrs_pkg::CHUNK_BYTES) ?
                         lrs_pkg::CHUNK_BYTES : {4'd0, in_q.bytes_moved};

  // ---------------------------------------------------------------------------
  // Next state and action for the item in the input register
  // ---------------------------------------------------------------------------
  always_comb begin
    st_d        = st_q;
    delay_d     = delay_q;
    last_d      = last_q;
    hs_start_d  = hs_start_q;
    err_start_d = err_start_q;
    total_d     = total_q;
    act         = lrs_pkg::ACT_NONE;

    case (st_q)
      lrs_pkg::SUP_WAIT_LINK: begin
        if (in_q.link_up) begin
          st_d   = lrs_pkg::SUP_IDLE;
          last_d = '0;
        end
      end
      lrs_pkg::SUP_IDLE: begin
        if (!in_q.link_up) begin
          st_d = lrs_pkg::SUP_WAIT_LINK;
        end else if (since_last < {16'd0, delay_q}) begin
          // hold until the reconnect delay has run out
        end else if (!in_q.server_known) begin
          last_d = in_q.now_ms;
        end else begin
          act = lrs_pkg::ACT_OPEN;
          if (in_q.open_ok) begin
            st_d = lrs_pkg::SUP_OPENING;
          end else begin
            last_d  = in_q.now_ms;
            delay_d = backoff_delay;
          end
        end
      end
      lrs_pkg::SUP_OPENING: begin
        act = (role_q == lrs_pkg::ROLE_SOURCE) ? lrs_pkg::ACT_SEND_SOURCE
                                               : lrs_pkg::ACT_SEND_ROVER;
        if (in_q.request_ok) begin
          hs_start_d = in_q.now_ms;
          st_d       = lrs_pkg::SUP_AWAIT_REPLY;
        end else begin
          last_d  = in_q.now_ms;
          delay_d = backoff_delay;
          st_d    = lrs_pkg::SUP_IDLE;
        end
      end
      lrs_pkg::SUP_AWAIT_REPLY: begin
        if (since_hs > {16'd0, hs_timeout_q}) begin
          act     = lrs_pkg::ACT_CLOSE;
          last_d  = in_q.now_ms;
          delay_d = backoff_delay;
          st_d    = lrs_pkg::SUP_IDLE;
        end else if (in_q.reply_seen) begin
          if (in_q.reply_accepted) begin
            delay_d = retry_init_q;
            st_d    = lrs_pkg::SUP_LIVE;
          end else if (in_q.reply_fatal) begin
            act         = lrs_pkg::ACT_CLOSE;
            err_start_d = in_q.now_ms;
            st_d        = lrs_pkg::SUP_FAULT;
          end else begin
            act     = lrs_pkg::ACT_CLOSE;
            last_d  = in_q.now_ms;
            delay_d = backoff_delay;
            st_d    = lrs_pkg::SUP_IDLE;
          end
        end
      end
      lrs_pkg::SUP_LIVE: begin
        if (!in_q.session_alive || !in_q.link_up) begin
          act    = lrs_pkg::ACT_CLOSE;
          last_d = in_q.now_ms;
          st_d   = lrs_pkg::SUP_IDLE;
        end else begin
          act     = lrs_pkg::ACT_TRANSFER;
          total_d = total_q + {19'd0, bytes_clip};
        end
      end
      lrs_pkg::SUP_FAULT: begin
        if (since_err > {12'd0, err_pause_q}) begin
          delay_d = retry_init_q;
          last_d  = '0;
          st_d    = lrs_pkg::SUP_IDLE;
        end
      end
      default: ;
    endcase

    out_d.state_code      = st_d;
    out_d.action          = act;
    out_d.streaming_flag  = (st_d == lrs_pkg::SUP_LIVE);
    out_d.byte_total_out  = total_d;
    out_d.retry_delay_out = delay_d;
  end

  // ---------------------------------------------------------------------------
  // State registers; a role write restarts the supervisor
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lrs_pkg::SUP_OFF;
      delay_q     <= lrs_pkg::RETRY_INITIAL_RST;
      last_q      <= '0;
      hs_start_q  <= '0;
      err_start_q <= '0;
      total_q     <= '0;
    end else if (role_wr) begin
      st_q    <= (cfg_wdata_i[1:0] == lrs_pkg::ROLE_SOURCE ||
                  cfg_wdata_i[1:0] == lrs_pkg::ROLE_ROVER) ? lrs_pkg::SUP_WAIT_LINK
                                                           : lrs_pkg::SUP_OFF;
      delay_q <= retry_init_q;
    end else if (adv) begin
      st_q        <= st_d;
      delay_q     <= delay_d;
      last_q      <= last_d;
      hs_start_q  <= hs_start_d;
      err_start_q <= err_start_d;
      total_q     <= total_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ld) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8*lrs_pkg::OUT_BYTES - $bits(lrs_pkg::out_item_t)){1'b0}}, out_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_role_disabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (role_q != lrs_pkg::ROLE_SOURCE && role_q != lrs_pkg::ROLE_ROVER) |->
      (st_q == lrs_pkg::SUP_OFF))
    else $error("supervisor active while role is disabled");

  a_role_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (role_q == lrs_pkg::ROLE_SOURCE || role_q == lrs_pkg::ROLE_ROVER) |->
      (st_q != lrs_pkg::SUP_OFF))
    else $error("supervisor disabled while role is active");

  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("item advanced without a result");

  a_total_only_streaming : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> $past(adv && st_q == lrs_pkg::SUP_LIVE))
    else $error("byte total moved outside a streaming pass");

  a_flag_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.streaming_flag == (out_q.state_code == lrs_pkg::SUP_LIVE)))
    else $error("streaming flag disagrees with state");

endmodule

// File: verif/testbench.sv
// Self-checking bench for link_reconnect_supervisor: a clocked driver and monitor
// on the item streams, with an in-bench predictor of the connection supervisor.
// Depends on lrs_pkg for the state, action, register codes and item layouts.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IN_W  = 8 * lrs_pkg::IN_BYTES;
  localparam int unsigned OUT_W = 8 * lrs_pkg::OUT_BYTES;

  // Give up after this many cycles in which neither stream moves an item
  localparam int unsigned QUIET_LIMIT = 5000;
  // Receiver hold-off used once to fill the block and stall its input
  localparam int unsigned CHOKE_CYCLES = 400;
  // Percent of cycles in which each side idles outside the steady stretch
  localparam int unsigned IDLE_PCT = 14;

  localparam logic [1:0] ROLE_OFF    = 2'd0;
  localparam logic [1:0] ROLE_UNUSED = 2'd3;

  // Flag masks for directed items, in the order of the flag bits of in_item_t
  localparam logic [7:0] F_LINK   = 8'h01;
  localparam logic [7:0] F_SERVER = 8'h02;
  localparam logic [7:0] F_OPEN   = 8'h04;
  localparam logic [7:0] F_REQ    = 8'h08;
  localparam logic [7:0] F_SEEN   = 8'h10;
  localparam logic [7:0] F_ACC    = 8'h20;
  localparam logic [7:0] F_FATAL  = 8'h40;
  localparam logic [7:0] F_ALIVE  = 8'h80;
  localparam logic [7:0] F_LS     = F_LINK | F_SERVER;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_addr_i = '0;
  logic [19:0]     cfg_wdata_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // Stimulus controls, written by the sequence at falling edges only
  logic steady = 1'b0;     // no random idling on either side
  logic hold_send = 1'b0;  // sender offers nothing new
  logic choke_go = 1'b0;   // request one long receiver hold-off

  lrs_pkg::in_item_t  pending_passes[$];
  lrs_pkg::out_item_t predicted_reports[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Predictor: configuration copy
  logic [1:0]  cfg_role = ROLE_OFF;
  logic [15:0] cfg_retry_init = lrs_pkg::RETRY_INITIAL_RST;
  logic [15:0] cfg_retry_cap = lrs_pkg::RETRY_MAX_RST;
  logic [15:0] cfg_hs_limit = lrs_pkg::HS_TIMEOUT_RST;
  logic [19:0] cfg_err_pause = lrs_pkg::ERROR_PAUSE_RST;

  // Predictor: supervisor state
  lrs_pkg::state_e sup_state = lrs_pkg::SUP_OFF;
  logic [15:0] sup_delay = lrs_pkg::RETRY_INITIAL_RST;
  logic [31:0] attempt_ms = '0;
  logic [31:0] hs_start_ms = '0;
  logic [31:0] err_start_ms = '0;
  logic [31:0] byte_sum = '0;

  link_reconnect_supervisor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Record the failed attempt and double the delay, capped at retry_max_ms.
  function automatic void lengthen_backoff(logic [31:0] at_ms);
    logic [16:0] twice;
    twice = {sup_delay, 1'b0};
    attempt_ms = at_ms;
    sup_delay = (twice < {1'b0, cfg_retry_cap}) ? twice[15:0] : cfg_retry_cap;
  endfunction

  // Advance the supervisor by one pass and return the report it produces.
  function automatic lrs_pkg::out_item_t advance_supervisor(lrs_pkg::in_item_t p);
    lrs_pkg::out_item_t r;
    lrs_pkg::action_e   act;
    logic [12:0] credit;
    logic [31:0] since;
    act = lrs_pkg::ACT_NONE;
    // Clamp oversized byte counts to one chunk
    credit = (13'(p.bytes_moved) > lrs_pkg::CHUNK_BYTES) ? lrs_pkg::CHUNK_BYTES :
                                                           13'(p.bytes_moved);
    case (sup_state)
      lrs_pkg::SUP_WAIT_LINK: begin
        if (p.link_up) begin
          sup_state = lrs_pkg::SUP_IDLE;
          attempt_ms = '0;
        end
      end
      lrs_pkg::SUP_IDLE: begin
        since = p.now_ms - attempt_ms;
        if (!p.link_up) begin
          sup_state = lrs_pkg::SUP_WAIT_LINK;
        end else if (since < {16'h0, sup_delay}) begin
          // still inside the reconnect delay
        end else if (!p.server_known) begin
          attempt_ms = p.now_ms;
        end else begin
          act = lrs_pkg::ACT_OPEN;
          if (p.open_ok) sup_state = lrs_pkg::SUP_OPENING;
          else lengthen_backoff(p.now_ms);
        end
      end
      lrs_pkg::SUP_OPENING: begin
        act = (cfg_role == lrs_pkg::ROLE_SOURCE) ? lrs_pkg::ACT_SEND_SOURCE :
                                                   lrs_pkg::ACT_SEND_ROVER;
        if (p.request_ok) begin
          hs_start_ms = p.now_ms;
          sup_state = lrs_pkg::SUP_AWAIT_REPLY;
        end else begin
          lengthen_backoff(p.now_ms);
          sup_state = lrs_pkg::SUP_IDLE;
        end
      end
      lrs_pkg::SUP_AWAIT_REPLY: begin
        since = p.now_ms - hs_start_ms;
        if (since > {16'h0, cfg_hs_limit}) begin
          act = lrs_pkg::ACT_CLOSE;
          lengthen_backoff(p.now_ms);
          sup_state = lrs_pkg::SUP_IDLE;
        end else if (p.reply_seen) begin
          if (p.reply_accepted) begin
            sup_delay = cfg_retry_init;
            sup_state = lrs_pkg::SUP_LIVE;
          end else if (p.reply_fatal) begin
            act = lrs_pkg::ACT_CLOSE;
            err_start_ms = p.now_ms;
            sup_state = lrs_pkg::SUP_FAULT;
          end else begin
            act = lrs_pkg::ACT_CLOSE;
            lengthen_backoff(p.now_ms);
            sup_state = lrs_pkg::SUP_IDLE;
          end
        end
      end
      lrs_pkg::SUP_LIVE: begin
        if (!p.session_alive || !p.link_up) begin
          act = lrs_pkg::ACT_CLOSE;
          attempt_ms = p.now_ms;
          sup_state = lrs_pkg::SUP_IDLE;
        end else begin
          act = lrs_pkg::ACT_TRANSFER;
          byte_sum = byte_sum + 32'(credit);
        end
      end
      lrs_pkg::SUP_FAULT: begin
        since = p.now_ms - err_start_ms;
        if (since > {12'h0, cfg_err_pause}) begin
          sup_delay = cfg_retry_init;
          attempt_ms = '0;
          sup_state = lrs_pkg::SUP_IDLE;
        end
      end
      default: begin
        // disabled: nothing moves
      end
    endcase
    r.state_code      = sup_state;
    r.action          = act;
    r.streaming_flag  = (sup_state == lrs_pkg::SUP_LIVE);
    r.byte_total_out  = byte_sum;
    r.retry_delay_out = sup_delay;
    return r;
  endfunction

  function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer pending items; predict each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_passes
    lrs_pkg::in_item_t taken;
    lrs_pkg::in_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken = s_axis_tdata[$bits(lrs_pkg::in_item_t)-1:0];
        predicted_reports.push_back(advance_supervisor(taken));
      end
      // Hold the current item until it is taken; only then pick the next one
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_passes.size() != 0 && !hold_send &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_passes.pop_front();
          s_axis_tdata  <= {{(IN_W - $bits(lrs_pkg::in_item_t)){1'b0}}, nxt};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each report with the oldest prediction; throttle tready
  // ---------------------------------------------------------------------------
  int unsigned choke_left = 0;
  logic        choke_taken = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : watch_reports
    lrs_pkg::out_item_t got;
    lrs_pkg::out_item_t want;
    logic      choke_start;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      choke_left    <= 0;
      choke_taken   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(lrs_pkg::out_item_t)-1:0];
        if (predicted_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: report with nothing predicted, expected none, actual %h",
                   $time, got);
        end else begin
          want = predicted_reports.pop_front();
          check_field("state_code", want.state_code, got.state_code);
          check_field("action", want.action, got.action);
          check_field("streaming_flag", want.streaming_flag, got.streaming_flag);
          check_field("byte_total_out", want.byte_total_out, got.byte_total_out);
          check_field("retry_delay_out", want.retry_delay_out, got.retry_delay_out);
        end
      end
      // Count the long hold-off here so the sender keeps offering meanwhile
      choke_start = choke_go && !choke_taken;
      if (choke_start) begin
        choke_taken <= 1'b1;
        choke_left  <= CHOKE_CYCLES;
      end else if (choke_left != 0) begin
        choke_left <= choke_left - 1;
      end
      m_axis_tready <= !choke_start && (choke_left == 0) &&
                       (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if both streams stay still for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the predictor; return on a falling edge.
  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lrs_pkg::CFG_ROLE_MODE: begin
        // A role write restarts the supervisor and restores the delay
        cfg_role  = val[1:0];
        sup_state = (cfg_role == lrs_pkg::ROLE_SOURCE || cfg_role == lrs_pkg::ROLE_ROVER) ?
                    lrs_pkg::SUP_WAIT_LINK : lrs_pkg::SUP_OFF;
        sup_delay = cfg_retry_init;
      end
      lrs_pkg::CFG_RETRY_INITIAL: cfg_retry_init = val[15:0];
      lrs_pkg::CFG_RETRY_MAX:     cfg_retry_cap  = val[15:0];
      lrs_pkg::CFG_HS_TIMEOUT:    cfg_hs_limit   = val[15:0];
      lrs_pkg::CFG_ERROR_PAUSE:   cfg_err_pause  = val;
      default: begin
        // out-of-range index: ignored
      end
    endcase
    @(negedge clk_i);
  endtask

  // Wait until nothing is queued, offered or predicted, then settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_passes.size() != 0 || s_axis_tvalid || predicted_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Drain, then write the timing registers and finally the role (which restarts).
  task automatic set_phase(input logic [1:0] role, input logic [15:0] init_ms,
                           input logic [15:0] cap_ms, input logic [15:0] hs_ms,
                           input logic [19:0] pause_ms);
    wait_idle();
    cfg_write(lrs_pkg::CFG_RETRY_INITIAL, 20'(init_ms));
    cfg_write(lrs_pkg::CFG_RETRY_MAX, 20'(cap_ms));
    cfg_write(lrs_pkg::CFG_HS_TIMEOUT, 20'(hs_ms));
    cfg_write(lrs_pkg::CFG_ERROR_PAUSE, pause_ms);
    cfg_write(lrs_pkg::CFG_ROLE_MODE, 20'(role));
  endtask

  task automatic push_pass(input logic [31:0] at_ms, input logic [7:0] flags,
                           input logic [8:0] nbytes);
    lrs_pkg::in_item_t it;
    it = {nbytes, flags, at_ms};
    pending_passes.push_back(it);
  endtask

  // Queue a session of passes with a mostly advancing clock and mostly
  // favorable outcomes, so the supervisor walks deep into its states;
  // a share of items is pure noise.
  task automatic queue_passes(input int count, input logic [31:0] start_ms);
    logic [31:0] ms;
    logic [63:0] raw;
    int unsigned sel;
    lrs_pkg::in_item_t it;
    ms = start_ms;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55)      ms += $urandom_range(0, 40);
      else if (sel < 90) ms += $urandom_range(0, 6000);
      else if (sel < 98) ms += $urandom_range(0, 80000);
      else               ms += $urandom_range(0, 2500000);
      if ($urandom_range(0, 99) < 12) begin
        raw = {$urandom, $urandom};
        it  = raw[$bits(lrs_pkg::in_item_t)-1:0];
      end else begin
        it.now_ms         = ms;
        it.link_up        = $urandom_range(0, 99) < 95;
        it.server_known   = $urandom_range(0, 99) < 90;
        it.open_ok        = $urandom_range(0, 99) < 80;
        it.request_ok     = $urandom_range(0, 99) < 80;
        it.reply_seen     = $urandom_range(0, 99) < 50;
        it.reply_accepted = $urandom_range(0, 99) < 50;
        it.reply_fatal    = $urandom_range(0, 99) < 50;
        it.session_alive  = $urandom_range(0, 99) < 94;
        it.bytes_moved    = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511)) :
                                                          9'($urandom_range(0, 256));
      end
      pending_passes.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset the role is off: everything is ignored
    push_pass(32'hFFFF_FFFF, 8'hFF, 9'h1FF);
    push_pass(32'h0, 8'h00, 9'h000);
    wait_idle();

    // Directed walk as source with zero delay and zero timeouts;
    // out-of-range register indexes must not disturb anything
    cfg_write(3'(lrs_pkg::CFG_ERROR_PAUSE) + 3'd1, 20'hFFFFF);
    cfg_write(3'(lrs_pkg::CFG_ERROR_PAUSE) + 3'd3, 20'h00001);
    set_phase(lrs_pkg::ROLE_SOURCE, 16'd0, 16'hFFFF, 16'd0, 20'd0);
    push_pass(32'd0, 8'h00, 9'd0);                 // no link: stay waiting
    push_pass(32'd1, F_LINK, 9'd0);                // link up: disconnected
    push_pass(32'd2, F_LINK, 9'd0);                // no server: restamp attempt
    push_pass(32'd3, F_LS, 9'd0);                  // open fails: back off from zero
    push_pass(32'd4, F_LS | F_OPEN, 9'd0);         // open succeeds
    push_pass(32'd5, F_LS, 9'd0);                  // request fails
    push_pass(32'd6, F_LS | F_OPEN, 9'd0);
    push_pass(32'd7, F_LS | F_REQ, 9'd0);          // handshake starts
    push_pass(32'd7, F_LS, 9'd0);                  // zero elapsed: keep waiting
    push_pass(32'd9, F_LS, 9'd0);                  // zero timeout expired: close
    push_pass(32'd10, F_LS | F_OPEN, 9'd0);
    push_pass(32'd11, F_LS | F_REQ, 9'd0);
    push_pass(32'd11, F_LS | F_SEEN | F_ACC | F_FATAL, 9'd0); // accept wins over fatal
    push_pass(32'd12, F_LS | F_ALIVE, 9'h1FF);     // oversized count clamps
    push_pass(32'd13, F_LS | F_ALIVE, 9'd256);
    push_pass(32'd14, F_LS | F_ALIVE, 9'd257);
    push_pass(32'd15, F_LS, 9'd5);                 // session dropped: close
    push_pass(32'd16, F_LS | F_OPEN, 9'd0);
    push_pass(32'd17, F_LS | F_REQ, 9'd0);
    push_pass(32'd17, F_LS | F_SEEN | F_FATAL, 9'd0); // fatal reply: error
    push_pass(32'd17, F_LS, 9'd0);                 // pause not over yet
    push_pass(32'd18, F_LS, 9'd0);                 // zero pause expired
    push_pass(32'd19, F_LS | F_OPEN, 9'd0);
    push_pass(32'd20, F_LS | F_REQ, 9'd0);
    push_pass(32'd20, F_LS | F_SEEN, 9'd0);        // plain rejection: close, back off

    // Rover with the widest limits, clock wrapping through zero
    set_phase(lrs_pkg::ROLE_ROVER, 16'd1, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
    queue_passes(150, 32'hFFFF_F000);

    // Initial delay above the cap, one-millisecond timeouts and pause
    set_phase(lrs_pkg::ROLE_SOURCE, 16'hFFFF, 16'd1, 16'd1, 20'd1);
    queue_passes(120, $urandom);

    // Steady stretch with no idling, then drain completely before resuming
    set_phase(lrs_pkg::ROLE_ROVER, 16'd10, 16'd200, 16'd300, 20'd500);
    steady = 1'b1;
    queue_passes(80, $urandom);
    do @(negedge clk_i); while (pending_passes.size() != 0);
    hold_send = 1'b1;
    do @(negedge clk_i); while (s_axis_tvalid || predicted_reports.size() != 0);
    hold_send = 1'b0;
    queue_passes(80, $urandom);
    do @(negedge clk_i); while (pending_passes.size() != 0);
    steady = 1'b0;

    // Unused role code behaves as disabled
    set_phase(ROLE_UNUSED, 16'd50, 16'd400, 16'd100, 20'd100);
    queue_passes(15, $urandom);

    // All timing registers zero
    set_phase(lrs_pkg::ROLE_SOURCE, 16'd0, 16'd0, 16'd0, 20'd0);
    queue_passes(130, $urandom);

    // Reset-like values; stall the receiver long enough to back up the input
    set_phase(lrs_pkg::ROLE_ROVER, lrs_pkg::RETRY_INITIAL_RST, lrs_pkg::RETRY_MAX_RST,
              lrs_pkg::HS_TIMEOUT_RST, lrs_pkg::ERROR_PAUSE_RST);
    choke_go = 1'b1;
    queue_passes(120, $urandom);

    set_phase(ROLE_OFF, 16'd1, 16'd1, 16'd1, 20'd1);
    queue_passes(10, $urandom);

    set_phase(lrs_pkg::ROLE_SOURCE, 16'($urandom_range(1, 3000)), 16'($urandom),
              16'($urandom), 20'($urandom));
    queue_passes(150, $urandom);

    set_phase(lrs_pkg::ROLE_ROVER, 16'd5, 16'hFFFF, 16'hFFFF, 20'd1);
    queue_passes(130, $urandom);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (predicted_reports.size() != 0)
        $display("%0t ns: %0d predicted reports never arrived", $time,
                 predicted_reports.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: link_reconnect_supervisor.f
rtl/lrs_pkg.sv
rtl/link_reconnect_supervisor.sv
verif/testbench.sv
